FILE: rtl/core/frr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frr_pkg: shared types and constants
// Request/result payload structs, protocol codes and CRC step function.
// ----------------------------------------------------------------------------
package frr_pkg;

    localparam int MAX_PAYLOAD_DEF = 96;

    localparam logic [7:0] SYNC_A       = 8'hA5;
    localparam logic [7:0] SYNC_B       = 8'h5A;
    localparam logic [7:0] PROTO_VER    = 8'h01;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0] FEATURE_BITS = 8'h07;

    localparam logic [7:0] TYPE_REQ = 8'h01;
    localparam logic [7:0] TYPE_RSP = 8'h02;
    localparam logic [7:0] TYPE_ERR = 8'h03;

    localparam logic [7:0] CMD_PING = 8'h01;
    localparam logic [7:0] CMD_INFO = 8'h02;
    localparam logic [7:0] CMD_TIME = 8'h03;

    localparam logic [7:0] ERR_CRC = 8'h01;
    localparam logic [7:0] ERR_LEN = 8'h02;
    localparam logic [7:0] ERR_VER = 8'h03;
    localparam logic [7:0] ERR_CMD = 8'h04;

    localparam logic [0:0] REG_FW_MAJOR = 1'd0;
    localparam logic [0:0] REG_FW_MINOR = 1'd1;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_now;
    } frr_in_t;

    typedef struct packed {
        logic [31:0] tx_word;
        logic [2:0]  tx_count;
        logic        frame_end;
    } frr_out_t;

    // one bit of reflected CRC-16
    function automatic logic [15:0] crc_bit(input logic [15:0] c);
        crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/framed_request_responder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_request_responder: framed request parser and reply generator
// Parses sync/header/payload/CRC, builds reply frames one byte at a time
// through a shared bit-serial CRC unit and packs them up to four bytes per result.
// ----------------------------------------------------------------------------
// Input stall: a header or payload byte holds the input through its CRC bit
// steps and evaluate; a sync or check byte holds it through evaluate only,
// and a reply that evaluate starts holds it until its last word is handed out.
// A reply byte under the CRC goes fetch, read wait, load, bit steps, flush; sync and
// check bytes skip the bit steps. Output stalls hold flush; the CRC shifter sets the pace.
// Reset: parser waits for the first sync byte, CRC reads 0xFFFF, no output.
module framed_request_responder
    import frr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire frr_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output frr_out_t      out_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_index,
    input  wire logic [7:0] cfg_data
);
    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int FW = $clog2(MAX_PAYLOAD + 11);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RXCRC = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_BYTE  = 4'd4;
    localparam logic [3:0] S_TXCRC = 4'd5;
    localparam logic [3:0] S_FLUSH = 4'd6;
    localparam logic [3:0] S_RDWAIT = 4'd7;

    // parse phases
    localparam logic [2:0] PH_SYNC_A  = 3'd0;
    localparam logic [2:0] PH_SYNC_B  = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHK_LO  = 3'd4;
    localparam logic [2:0] PH_CHK_HI  = 3'd5;

    // eval outcomes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_HDR  = 2'd1;
    localparam logic [1:0] EV_CHK  = 2'd2;

    // reply body kinds
    localparam logic [1:0] RK_ERR  = 2'd0;
    localparam logic [1:0] RK_PING = 2'd1;
    localparam logic [1:0] RK_INFO = 2'd2;
    localparam logic [1:0] RK_TIME = 2'd3;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hdr_reg [6];
    logic [2:0]  hpos_reg, hpos_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic [PW-1:0] ppos_reg, ppos_next;
    logic [7:0]  chklo_reg, chklo_next;
    logic [7:0]  byte_reg, byte_next;
    logic [31:0] time_reg, time_next;
    logic [1:0]  ev_reg, ev_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  fw_major_reg, fw_minor_reg;
    logic [15:0] rxcrc_reg, rxcrc_next;

    // reply frame descriptor
    logic [7:0]  rtype_reg, rtype_next;
    logic [7:0]  rcode_reg, rcode_next;
    logic [1:0]  rkind_reg, rkind_next;   // reply body kind
    logic [PW-1:0] rlen_reg, rlen_next;
    logic [FW-1:0] fidx_reg, fidx_next;
    logic [7:0]  fbyte_reg, fbyte_next;

    // output packer
    logic [31:0] pack_reg, pack_next;
    logic [2:0]  pcnt_reg, pcnt_next;
    logic        ov_reg, ov_next;
    frr_out_t    od_reg, od_next;

    // payload memory
    logic [7:0]  pmem [MAX_PAYLOAD];
    logic        pm_we;
    logic [AW-1:0] pm_waddr, pm_raddr;
    logic [7:0]  pm_rdata;

    // shared CRC unit
    logic        crc_init, crc_load, crc_step;
    logic [7:0]  crc_data;
    logic [15:0] crc;

    frr_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .init  (crc_init),
        .load  (crc_load),
        .data  (crc_data),
        .step  (crc_step),
        .crc   (crc)
    );

    always_ff @(posedge clk)
    begin
        if (pm_we)
            pmem[pm_waddr] <= byte_reg;
        pm_rdata <= pmem[pm_raddr];
    end

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    logic [15:0] hlen;
    assign hlen = {hdr_reg[5], hdr_reg[4]};
    logic [FW-1:0] flen;
    assign flen = FW'(rlen_reg) + FW'(10);
    logic [7:0] maxp_lo, maxp_hi;
    assign maxp_lo = 8'(MAX_PAYLOAD);
    assign maxp_hi = 8'(MAX_PAYLOAD >> 8);
    logic [FW-1:0] body_idx;
    assign body_idx = fidx_reg - FW'(8);
    assign pm_raddr = AW'(body_idx);

    // frame byte select
    logic [7:0] frame_byte;
    always_comb
    begin
        frame_byte = 8'h00;
        if (fidx_reg == FW'(0))       frame_byte = SYNC_A;
        else if (fidx_reg == FW'(1))  frame_byte = SYNC_B;
        else if (fidx_reg == FW'(2))  frame_byte = PROTO_VER;
        else if (fidx_reg == FW'(3))  frame_byte = rtype_reg;
        else if (fidx_reg == FW'(4))  frame_byte = hdr_reg[2];
        else if (fidx_reg == FW'(5))  frame_byte = hdr_reg[3];
        else if (fidx_reg == FW'(6))  frame_byte = 8'(rlen_reg);
        else if (fidx_reg == FW'(7))  frame_byte = 8'(FW'(rlen_reg) >> 8);
        else if (fidx_reg == flen - FW'(2)) frame_byte = crc[7:0];
        else if (fidx_reg == flen - FW'(1)) frame_byte = crc[15:8];
        else
        begin
            unique case (rkind_reg)
                RK_ERR: frame_byte = rcode_reg;
                RK_PING: frame_byte = pm_rdata;
                RK_INFO:
                begin
                    unique case (body_idx[2:0])
                        3'd0: frame_byte = PROTO_VER;
                        3'd1: frame_byte = maxp_lo;
                        3'd2: frame_byte = maxp_hi;
                        3'd3: frame_byte = FEATURE_BITS;
                        3'd4: frame_byte = fw_major_reg;
                        3'd5: frame_byte = fw_minor_reg;
                        default: frame_byte = 8'h00;
                    endcase
                end
                default:
                begin
                    unique case (body_idx[1:0])
                        2'd0: frame_byte = time_reg[7:0];
                        2'd1: frame_byte = time_reg[15:8];
                        2'd2: frame_byte = time_reg[23:16];
                        default: frame_byte = time_reg[31:24];
                    endcase
                end
            endcase
        end
    end

    logic is_last;
    assign is_last = (fidx_reg == flen - FW'(1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        plen_next  = plen_reg;
        ppos_next  = ppos_reg;
        chklo_next = chklo_reg;
        byte_next  = byte_reg;
        time_next  = time_reg;
        ev_next    = ev_reg;
        bit_next   = bit_reg;
        rxcrc_next = rxcrc_reg;
        rtype_next = rtype_reg;
        rcode_next = rcode_reg;
        rkind_next = rkind_reg;
        rlen_next  = rlen_reg;
        fidx_next  = fidx_reg;
        fbyte_next = fbyte_reg;
        pack_next  = pack_reg;
        pcnt_next  = pcnt_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        crc_init = 1'b0;
        crc_load = 1'b0;
        crc_step = 1'b0;
        crc_data = byte_reg;
        pm_we    = 1'b0;
        pm_waddr = AW'(ppos_reg);

        if (out_acc)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    byte_next = in_data.rx_byte;
                    time_next = in_data.time_now;
                    ev_next   = EV_NONE;
                    state_next = S_EVAL;
                    unique case (phase_reg)
                        PH_SYNC_A:
                            if (in_data.rx_byte == SYNC_A)
                                phase_next = PH_SYNC_B;
                        PH_SYNC_B:
                            if (in_data.rx_byte == SYNC_B)
                            begin
                                phase_next = PH_HEADER;
                                hpos_next = 3'd0;
                                ppos_next = '0;
                                plen_next = '0;
                                crc_init  = 1'b1;
                            end
                            else if (in_data.rx_byte != SYNC_A)
                                phase_next = PH_SYNC_A;
                        PH_HEADER:
                        begin
                            hpos_next = hpos_reg + 3'd1;
                            crc_data = in_data.rx_byte;
                            crc_load = 1'b1;
                            bit_next = 3'd0;
                            state_next = S_RXCRC;
                            if (hpos_reg == 3'd5)
                                ev_next = EV_HDR;
                        end
                        PH_PAYLOAD:
                        begin
                            ppos_next = ppos_reg + PW'(1);
                            crc_data = in_data.rx_byte;
                            crc_load = 1'b1;
                            bit_next = 3'd0;
                            state_next = S_RXCRC;
                            if (ppos_reg + PW'(1) >= plen_reg)
                                phase_next = PH_CHK_LO;
                        end
                        PH_CHK_LO:
                        begin
                            chklo_next = in_data.rx_byte;
                            phase_next = PH_CHK_HI;
                        end
                        PH_CHK_HI:
                        begin
                            ev_next = EV_CHK;
                            rxcrc_next = crc;
                            phase_next = PH_SYNC_A;
                        end
                        default:
                            phase_next = PH_SYNC_A;
                    endcase
                end
            end
            S_RXCRC:
            begin
                crc_step = 1'b1;
                bit_next = bit_reg + 3'd1;
                if (phase_reg == PH_CHK_LO && bit_reg == 3'd0 &&
                    ppos_reg != '0)
                    pm_we = 1'b0;
                if (bit_reg == 3'd7)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                rkind_next = RK_ERR;
                rlen_next  = PW'(1);
                rtype_next = TYPE_ERR;
                if (ev_reg == EV_HDR)
                begin
                    plen_next = PW'(hlen);
                    if (hdr_reg[0] != PROTO_VER)
                    begin
                        rcode_next = ERR_VER;
                        state_next = S_FETCH;
                        phase_next = PH_SYNC_A;
                    end
                    else if (hlen > 16'(MAX_PAYLOAD))
                    begin
                        rcode_next = ERR_LEN;
                        state_next = S_FETCH;
                        phase_next = PH_SYNC_A;
                    end
                    else if (hlen == 16'd0)
                        phase_next = PH_CHK_LO;
                    else
                    begin
                        ppos_next = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                else if (ev_reg == EV_CHK)
                begin
                    if ({byte_reg, chklo_reg} != rxcrc_reg)
                    begin
                        rcode_next = ERR_CRC;
                        state_next = S_FETCH;
                    end
                    else if (hdr_reg[1] == TYPE_REQ)
                    begin
                        state_next = S_FETCH;
                        rtype_next = TYPE_RSP;
                        if (hdr_reg[3] == CMD_PING)
                        begin
                            rkind_next = RK_PING;
                            rlen_next = plen_reg;
                        end
                        else if (hdr_reg[3] == CMD_INFO)
                        begin
                            rkind_next = RK_INFO;
                            rlen_next = PW'(8);
                        end
                        else if (hdr_reg[3] == CMD_TIME)
                        begin
                            rkind_next = RK_TIME;
                            rlen_next = PW'(4);
                        end
                        else
                        begin
                            rtype_next = TYPE_ERR;
                            rcode_next = ERR_CMD;
                        end
                    end
                end
                if (state_next == S_FETCH)
                begin
                    fidx_next = '0;
                    pcnt_next = 3'd0;
                    pack_next = '0;
                    crc_init = 1'b1;
                    hpos_next = 3'd0;
                    ppos_next = (ev_reg == EV_HDR) ? '0 : ppos_reg;
                    if (ev_reg == EV_HDR)
                        plen_next = '0;
                end
                else if (ev_reg == EV_CHK)
                begin
                    crc_init = 1'b1;
                    plen_next = '0;
                    ppos_next = '0;
                    hpos_next = 3'd0;
                end
                // payload byte store happens once its CRC pass ends
                if (ev_reg == EV_NONE && (phase_reg == PH_PAYLOAD ||
                    phase_reg == PH_CHK_LO) && ppos_reg != '0 &&
                    hpos_reg == 3'd6)
                begin
                    pm_we = 1'b1;
                    pm_waddr = AW'(ppos_reg - PW'(1));
                end
            end
            S_FETCH:
                state_next = S_RDWAIT;
            S_RDWAIT:
            begin
                // memory read data for this index is now valid
                fbyte_next = frame_byte;
                state_next = S_BYTE;
            end
            S_BYTE:
            begin
                if (!ov_next || pcnt_reg != 3'd4)
                begin
                    if (fidx_reg >= FW'(2) && fidx_reg < flen - FW'(2))
                    begin
                        crc_data = fbyte_reg;
                        crc_load = 1'b1;
                        bit_next = 3'd0;
                        state_next = S_TXCRC;
                    end
                    else
                        state_next = S_FLUSH;
                    unique case (pcnt_reg[1:0])
                        2'd0: pack_next[7:0]   = fbyte_reg;
                        2'd1: pack_next[15:8]  = fbyte_reg;
                        2'd2: pack_next[23:16] = fbyte_reg;
                        default: pack_next[31:24] = fbyte_reg;
                    endcase
                    pcnt_next = pcnt_reg + 3'd1;
                end
            end
            S_TXCRC:
            begin
                crc_step = 1'b1;
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                    state_next = S_FLUSH;
            end
            default:
            begin
                // S_FLUSH: hand a full or final word to the output register, else move to the next byte
                if (pcnt_reg == 3'd4 || is_last)
                begin
                    if (!ov_next)
                    begin
                        ov_next = 1'b1;
                        od_next.tx_word = pack_reg;
                        od_next.tx_count = pcnt_reg;
                        od_next.frame_end = is_last;
                        pcnt_next = 3'd0;
                        pack_next = '0;
                        if (is_last)
                            state_next = S_IDLE;
                        else
                        begin
                            fidx_next = fidx_reg + FW'(1);
                            state_next = S_FETCH;
                        end
                    end
                end
                else
                begin
                    fidx_next = fidx_reg + FW'(1);
                    state_next = S_FETCH;
                end
            end
        endcase
    end

    // header store
    always_ff @(posedge clk)
    begin
        if (in_acc && phase_reg == PH_HEADER && hpos_reg < 3'd6)
            hdr_reg[hpos_reg] <= in_data.rx_byte;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_major_reg <= 8'd1;
            fw_minor_reg <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FW_MAJOR)
                fw_major_reg <= cfg_data;
            else
                fw_minor_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_SYNC_A;
            hpos_reg  <= '0;
            plen_reg  <= '0;
            ppos_reg  <= '0;
            chklo_reg <= '0;
            ev_reg    <= EV_NONE;
            bit_reg   <= '0;
            fidx_reg  <= '0;
            pcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            plen_reg  <= plen_next;
            ppos_reg  <= ppos_next;
            chklo_reg <= chklo_next;
            ev_reg    <= ev_next;
            bit_reg   <= bit_next;
            fidx_reg  <= fidx_next;
            pcnt_reg  <= pcnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        time_reg  <= time_next;
        rxcrc_reg <= rxcrc_next;
        rtype_reg <= rtype_next;
        rcode_reg <= rcode_next;
        rkind_reg <= rkind_next;
        rlen_reg  <= rlen_next;
        fbyte_reg <= fbyte_next;
        pack_reg  <= pack_next;
        od_reg    <= od_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_acc)
        else $error("request accepted while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.tx_count != 3'd0 && out_data.tx_count <= 3'd4))
        else $error("bad tx_count");
    a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= 3'd4)
        else $error("packer overflow");
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && state_next == S_IDLE) |=> out_data.frame_end)
        else $error("frame end missing");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/frr_crc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frr_crc: bit-serial CRC-16/Modbus unit
// Load xors a byte in; each step shifts one bit. Eight steps per byte.
// ----------------------------------------------------------------------------
module frr_crc
    import frr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        init,
    input  wire logic        load,
    input  wire logic [7:0]  data,
    input  wire logic        step,
    output logic [15:0]      crc
);
    logic [15:0] crc_reg, crc_next;

    // init has priority, then byte load, then bit shift
    always_comb
    begin
        crc_next = crc_reg;
        priority if (init)
            crc_next = CRC_INIT;
        else if (load)
            crc_next = crc_reg ^ {8'h00, data};
        else if (step)
            crc_next = crc_bit(crc_reg);
        else
            crc_next = crc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;
endmodule
`default_nettype wire
